### design/voice_command_frame_filter_macros.svh
`ifndef VOICE_COMMAND_FRAME_FILTER_MACROS_SVH
`define VOICE_COMMAND_FRAME_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define VCFF_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VCFF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### design/vcff_pkg.sv
package vcff_pkg;

    localparam int FRAME_LEN = 5;
    localparam int BEAT_W    = $clog2(FRAME_LEN);
    localparam int ADDR_W    = 4;

    localparam logic [7:0] SYNC0_BYTE   = 8'hAA;
    localparam logic [7:0] SYNC1_BYTE   = 8'h55;
    localparam logic [7:0] TAIL_BYTE    = 8'hFB;
    localparam logic [7:0] CMD_TYPE_SYS = 8'h01;
    localparam logic [7:0] CMD_ID_SLEEP = 8'h01;
    localparam logic [7:0] CMD_ID_WAKE  = 8'h02;

    localparam logic [31:0] WAKE_TIMEOUT_RST  = 32'd30000;
    localparam logic [31:0] ECHO_WINDOW_RST   = 32'd300;
    localparam logic [31:0] REPEAT_WINDOW_RST = 32'd100;
    localparam logic [31:0] REPLAY_WINDOW_RST = 32'd1000;

    typedef enum logic [2:0] {
        KIND_RX   = 3'd0,
        KIND_TICK = 3'd1,
        KIND_PLAY = 3'd2,
        KIND_STOP = 3'd3,
        KIND_WAKE = 3'd4
    } vcff_kind_t;

    typedef enum logic [1:0] {
        REG_WAKE_TIMEOUT  = 2'd0,
        REG_ECHO_WINDOW   = 2'd1,
        REG_REPEAT_WINDOW = 2'd2,
        REG_REPLAY_WINDOW = 2'd3
    } vcff_reg_t;

    localparam logic OUT_CMD = 1'b0;
    localparam logic OUT_TX  = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rx_byte;
        logic [7:0] play_type;
        logic [7:0] play_id;
        logic       alarm_ringing;
        logic       empty_box_alarm;
    } vcff_in_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  command_type;
        logic [7:0]  command_id;
        logic [7:0]  tx_byte;
        logic        last;
        logic        awake;
        logic        playing;
        logic [31:0] frame_count;
    } vcff_out_t;

    typedef struct packed {
        logic [31:0] wake_timeout;
        logic [31:0] echo_window;
        logic [31:0] repeat_window;
        logic [31:0] replay_window;
    } vcff_cfg_t;

    // request from the filter core to the result stage
    typedef struct packed {
        logic        is_play;
        logic [7:0]  code_type;
        logic [7:0]  code_id;
        logic        awake;
        logic        playing;
        logic [31:0] frame_count;
    } vcff_load_t;

endpackage

### design/voice_command_frame_filter.sv
// channel   | handshake         | payload
// ----------+-------------------+---------------------------------------
// input     | s_valid / s_ready | s_data  (vcff_in_t: byte, tick, play...)
// result    | m_valid / m_ready | m_data  (vcff_out_t: command or tx byte)
// config    | apb psel/penable  | paddr, pwdata, prdata
//
// one item is accepted per cycle while s_ready is high; m_valid is a registered flag
// a play frame holds the result register for five beats, one byte per unstalled cycle
// an item that needs the busy result register waits in the input register, s_ready low
// items that cause no result retire even while the result register is busy
// aresetn is synchronous; the wake/play flags and all filter state but the frame bytes clear
module voice_command_frame_filter
    import vcff_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vcff_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vcff_out_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    vcff_cfg_t  cfg;
    logic       in_vld_reg;
    vcff_in_t   in_data_reg;
    logic       take;
    logic       load_vld;
    vcff_load_t load;
    logic       out_ready;

    assign s_ready = !in_vld_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    vcff_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vcff_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item_vld  (in_vld_reg),
        .item      (in_data_reg),
        .out_ready (out_ready),
        .take      (take),
        .load_vld  (load_vld),
        .load      (load)
    );

    vcff_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_vld  (load_vld),
        .load      (load),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### design/vcff_regs.sv
module vcff_regs
    import vcff_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output vcff_cfg_t         cfg
);

    vcff_cfg_t cfg_reg;
    vcff_reg_t sel;
    logic      wr_en;

    assign sel    = vcff_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wake_timeout  <= WAKE_TIMEOUT_RST;
            cfg_reg.echo_window   <= ECHO_WINDOW_RST;
            cfg_reg.repeat_window <= REPEAT_WINDOW_RST;
            cfg_reg.replay_window <= REPLAY_WINDOW_RST;
        end else if (wr_en) begin
            case (sel)
                REG_WAKE_TIMEOUT:  cfg_reg.wake_timeout  <= pwdata;
                REG_ECHO_WINDOW:   cfg_reg.echo_window   <= pwdata;
                REG_REPEAT_WINDOW: cfg_reg.repeat_window <= pwdata;
                REG_REPLAY_WINDOW: cfg_reg.replay_window <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_WAKE_TIMEOUT:  prdata = cfg_reg.wake_timeout;
            REG_ECHO_WINDOW:   prdata = cfg_reg.echo_window;
            REG_REPEAT_WINDOW: prdata = cfg_reg.repeat_window;
            REG_REPLAY_WINDOW: prdata = cfg_reg.replay_window;
            default:           prdata = 32'd0;
        endcase
    end

endmodule

### design/vcff_core.sv
module vcff_core
    import vcff_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  vcff_cfg_t  cfg,
    input  logic       item_vld,
    input  vcff_in_t   item,
    input  logic       out_ready,
    output logic       take,
    output logic       load_vld,
    output vcff_load_t load
);

    logic [31:0]       now_ticks_reg, now_ticks_next;
    logic [BEAT_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]        fb_reg [4];
    logic [7:0]        prev_type_reg, prev_type_next;
    logic [7:0]        prev_id_reg, prev_id_next;
    logic [31:0]       prev_time_reg, prev_time_next;
    logic              awake_reg, awake_next;
    logic [31:0]       wake_stamp_reg, wake_stamp_next;
    logic              echo_armed_reg, echo_armed_next;
    logic [7:0]        sent_type_reg, sent_type_next;
    logic [7:0]        sent_id_reg, sent_id_next;
    logic [31:0]       sent_stamp_reg, sent_stamp_next;
    logic              play_reg, play_next;
    logic [7:0]        played_type_reg, played_type_next;
    logic [7:0]        played_id_reg, played_id_next;
    logic [31:0]       played_stamp_reg, played_stamp_next;
    logic [31:0]       count_reg, count_next;

    vcff_kind_t  kind;
    logic        hold;
    logic        is_rx, is_tick, is_play, is_stop, is_wake;
    logic        store_byte, frame_ok, fresh, deliver;
    logic [7:0]  ty, id;
    logic [31:0] sent_el, prev_el, wake_el, played_el, echo_el;
    logic        echo_hit, rep_hit, awake_chk, awake_ww;
    logic        is_sys, is_sleep, is_wakeword;
    logic        play_dup, play_go, needs_out;

    assign kind = vcff_kind_t'(item.kind);
    assign hold = item.alarm_ringing || item.empty_box_alarm;

    always_comb begin
        is_rx   = 1'b0;
        is_tick = 1'b0;
        is_play = 1'b0;
        is_stop = 1'b0;
        is_wake = 1'b0;
        case (kind)
            KIND_RX:   is_rx   = 1'b1;
            KIND_TICK: is_tick = 1'b1;
            KIND_PLAY: is_play = 1'b1;
            KIND_STOP: is_stop = 1'b1;
            KIND_WAKE: is_wake = 1'b1;
            default: ;
        endcase
    end

    assign sent_el   = now_ticks_reg - sent_stamp_reg;
    assign prev_el   = now_ticks_reg - prev_time_reg;
    assign wake_el   = now_ticks_reg - wake_stamp_reg;
    assign played_el = now_ticks_reg - played_stamp_reg;

    // frame assembly
    assign store_byte = byte_pos_reg < BEAT_W'(FRAME_LEN - 1);
    assign ty         = fb_reg[2];
    assign id         = fb_reg[3];
    assign frame_ok   = is_rx && !store_byte && fb_reg[0] == SYNC0_BYTE
                        && fb_reg[1] == SYNC1_BYTE && item.rx_byte == TAIL_BYTE;

    assign echo_hit = echo_armed_reg && ty == sent_type_reg && id == sent_id_reg
                      && sent_el < cfg.echo_window;
    assign rep_hit  = ty == prev_type_reg && id == prev_id_reg
                      && prev_el < cfg.repeat_window;
    assign fresh    = frame_ok && !echo_hit && !rep_hit;

    assign is_sys      = ty == CMD_TYPE_SYS;
    assign is_sleep    = is_sys && id == CMD_ID_SLEEP;
    assign is_wakeword = is_sys && id == CMD_ID_WAKE;

    // inactivity timeout, held off by alarms and playback
    assign awake_chk = awake_reg
                       && !(!hold && !play_reg && wake_el > cfg.wake_timeout);
    assign awake_ww  = awake_chk || is_wakeword;
    assign deliver   = fresh && (is_sleep || awake_ww);

    assign play_dup = play_reg && item.play_type == played_type_reg
                      && item.play_id == played_id_reg && played_el < cfg.replay_window;
    assign play_go  = is_play && !play_dup;

    assign needs_out = deliver || play_go;
    assign take      = item_vld && (!needs_out || out_ready);
    assign load_vld  = take && needs_out;

    // echo expiry looks at the tick count after this item
    assign echo_el = sent_el + {31'd0, is_tick};

    always_comb begin
        now_ticks_next    = now_ticks_reg;
        byte_pos_next     = byte_pos_reg;
        prev_type_next    = prev_type_reg;
        prev_id_next      = prev_id_reg;
        prev_time_next    = prev_time_reg;
        awake_next        = awake_reg;
        wake_stamp_next   = wake_stamp_reg;
        echo_armed_next   = echo_armed_reg;
        sent_type_next    = sent_type_reg;
        sent_id_next      = sent_id_reg;
        sent_stamp_next   = sent_stamp_reg;
        play_next         = play_reg;
        played_type_next  = played_type_reg;
        played_id_next    = played_id_reg;
        played_stamp_next = played_stamp_reg;
        count_next        = count_reg;

        if (is_rx) begin
            byte_pos_next = store_byte ? byte_pos_reg + BEAT_W'(1) : '0;
        end
        if (fresh) begin
            prev_type_next = ty;
            prev_id_next   = id;
            prev_time_next = now_ticks_reg;
            count_next     = count_reg + 32'd1;
            if (is_sleep) begin
                awake_next = awake_ww && (hold || play_reg);
            end else begin
                awake_next = awake_ww;
                if (awake_ww) begin
                    wake_stamp_next = now_ticks_reg;
                end
            end
        end
        if (is_tick) begin
            now_ticks_next = now_ticks_reg + 32'd1;
        end
        if (play_go) begin
            play_next         = 1'b1;
            played_type_next  = item.play_type;
            played_id_next    = item.play_id;
            played_stamp_next = now_ticks_reg;
            sent_type_next    = item.play_type;
            sent_id_next      = item.play_id;
            sent_stamp_next   = now_ticks_reg;
            echo_armed_next   = 1'b1;
        end else if (echo_el > cfg.echo_window) begin
            echo_armed_next = 1'b0;
        end
        if (is_stop) begin
            play_next        = 1'b0;
            played_type_next = 8'd0;
            played_id_next   = 8'd0;
        end
        if (is_wake) begin
            awake_next      = 1'b1;
            wake_stamp_next = now_ticks_reg;
        end
    end

    always_comb begin
        load.is_play     = play_go;
        load.code_type   = play_go ? item.play_type : ty;
        load.code_id     = play_go ? item.play_id : id;
        load.awake       = awake_next;
        load.playing     = play_next;
        load.frame_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_ticks_reg    <= '0;
            byte_pos_reg     <= '0;
            prev_type_reg    <= '0;
            prev_id_reg      <= '0;
            prev_time_reg    <= '0;
            awake_reg        <= 1'b0;
            wake_stamp_reg   <= '0;
            echo_armed_reg   <= 1'b0;
            sent_type_reg    <= '0;
            sent_id_reg      <= '0;
            sent_stamp_reg   <= '0;
            play_reg         <= 1'b0;
            played_type_reg  <= '0;
            played_id_reg    <= '0;
            played_stamp_reg <= '0;
            count_reg        <= '0;
        end else if (take) begin
            now_ticks_reg    <= now_ticks_next;
            byte_pos_reg     <= byte_pos_next;
            prev_type_reg    <= prev_type_next;
            prev_id_reg      <= prev_id_next;
            prev_time_reg    <= prev_time_next;
            awake_reg        <= awake_next;
            wake_stamp_reg   <= wake_stamp_next;
            echo_armed_reg   <= echo_armed_next;
            sent_type_reg    <= sent_type_next;
            sent_id_reg      <= sent_id_next;
            sent_stamp_reg   <= sent_stamp_next;
            play_reg         <= play_next;
            played_type_reg  <= played_type_next;
            played_id_reg    <= played_id_next;
            played_stamp_reg <= played_stamp_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && is_rx && store_byte) begin
            fb_reg[byte_pos_reg[1:0]] <= item.rx_byte;
        end
    end

endmodule

### design/vcff_out.sv
`include "voice_command_frame_filter_macros.svh"

module vcff_out
    import vcff_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_vld,
    input  vcff_load_t load,
    output logic       out_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output vcff_out_t  m_data
);

    logic              vld_reg;
    logic [BEAT_W-1:0] beat_reg;
    vcff_load_t        res_reg;
    logic              last_now;
    logic [7:0]        tx;

    assign last_now  = !res_reg.is_play || beat_reg == BEAT_W'(FRAME_LEN - 1);
    assign out_ready = !vld_reg || (m_ready && last_now);
    assign m_valid   = vld_reg;

    always_comb begin
        case (beat_reg)
            BEAT_W'(0): tx = SYNC0_BYTE;
            BEAT_W'(1): tx = SYNC1_BYTE;
            BEAT_W'(2): tx = res_reg.code_type;
            BEAT_W'(3): tx = res_reg.code_id;
            default:    tx = TAIL_BYTE;
        endcase
    end

    always_comb begin
        m_data.out_kind     = res_reg.is_play ? OUT_TX : OUT_CMD;
        m_data.command_type = res_reg.is_play ? 8'd0 : res_reg.code_type;
        m_data.command_id   = res_reg.is_play ? 8'd0 : res_reg.code_id;
        m_data.tx_byte      = res_reg.is_play ? tx : 8'd0;
        m_data.last         = last_now;
        m_data.awake        = res_reg.awake;
        m_data.playing      = res_reg.playing;
        m_data.frame_count  = res_reg.frame_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= 1'b0;
            beat_reg <= '0;
        end else if (load_vld) begin
            vld_reg  <= 1'b1;
            beat_reg <= '0;
        end else if (vld_reg && m_ready) begin
            if (last_now) begin
                vld_reg <= 1'b0;
            end else begin
                beat_reg <= beat_reg + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_vld) begin
            res_reg <= load;
        end
    end

    `VCFF_ASSERT_NOW(a_no_overwrite, load_vld, out_ready, "result loaded over a pending beat")
    `VCFF_ASSERT_NOW(a_beat_range, vld_reg, beat_reg <= BEAT_W'(FRAME_LEN - 1), "beat out of range")
    `VCFF_ASSERT_NOW(a_cmd_single, vld_reg && !res_reg.is_play, beat_reg == '0, "command beat moved")
    `VCFF_ASSERT_NEXT(a_beat_step, vld_reg && m_ready && !last_now, vld_reg && beat_reg == $past(beat_reg) + BEAT_W'(1), "frame beat skipped")

endmodule

### tb/vcff_stream_checker.sv
`timescale 1ns / 1ps

module vcff_stream_checker
    import vcff_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  vcff_in_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  vcff_out_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    // register copy
    logic [31:0] wake_limit;
    logic [31:0] echo_span;
    logic [31:0] repeat_span;
    logic [31:0] replay_span;

    // filter state
    logic [31:0] tick_now;
    logic [2:0]  rx_pos;
    logic [7:0]  hdr_buf [4];
    logic [7:0]  seen_type;
    logic [7:0]  seen_id;
    logic [31:0] seen_at;
    logic        awake_q;
    logic [31:0] wake_at;
    logic        echo_live;
    logic [7:0]  echo_type;
    logic [7:0]  echo_id;
    logic [31:0] echo_at;
    logic        play_live;
    logic [7:0]  play_type_q;
    logic [7:0]  play_id_q;
    logic [31:0] play_at;
    logic [31:0] cmd_total;

    vcff_out_t results_due [$];

    function automatic void clear_filter();
        wake_limit    = WAKE_TIMEOUT_RST;
        echo_span     = ECHO_WINDOW_RST;
        repeat_span   = REPEAT_WINDOW_RST;
        replay_span   = REPLAY_WINDOW_RST;
        tick_now      = '0;
        rx_pos        = '0;
        for (int i = 0; i < 4; i++) hdr_buf[i] = '0;
        seen_type     = '0;
        seen_id       = '0;
        seen_at       = '0;
        awake_q       = 1'b0;
        wake_at       = '0;
        echo_live     = 1'b0;
        echo_type     = '0;
        echo_id       = '0;
        echo_at       = '0;
        play_live     = 1'b0;
        play_type_q   = '0;
        play_id_q     = '0;
        play_at       = '0;
        cmd_total     = '0;
    endfunction

    function automatic void push_result(logic okind, logic [7:0] ty, logic [7:0] id,
                                        logic [7:0] tx, logic lst);
        vcff_out_t r;
        r.out_kind     = okind;
        r.command_type = ty;
        r.command_id   = id;
        r.tx_byte      = tx;
        r.last         = lst;
        r.awake        = awake_q;
        r.playing      = play_live;
        r.frame_count  = cmd_total;
        results_due.push_back(r);
    endfunction

    // decides whether a well-formed frame is delivered, updating wake and repeat state
    function automatic bit admit_command(logic [7:0] ty, logic [7:0] id, logic hold);
        if (echo_live && ty == echo_type && id == echo_id && (tick_now - echo_at) < echo_span)
            return 1'b0;
        if (ty == seen_type && id == seen_id && (tick_now - seen_at) < repeat_span)
            return 1'b0;
        seen_type = ty;
        seen_id   = id;
        seen_at   = tick_now;
        cmd_total++;
        if (awake_q && !hold && !play_live && (tick_now - wake_at) > wake_limit)
            awake_q = 1'b0;
        if (ty == CMD_TYPE_SYS && id == CMD_ID_WAKE) begin
            awake_q = 1'b1;
            wake_at = tick_now;
        end
        if (ty == CMD_TYPE_SYS && id == CMD_ID_SLEEP) begin
            if (!hold && !play_live)
                awake_q = 1'b0;
            return 1'b1;
        end
        if (!awake_q)
            return 1'b0;
        wake_at = tick_now;
        return 1'b1;
    endfunction

    function automatic void filter_item(vcff_in_t it);
        logic       hold;
        logic [7:0] tx_seq [FRAME_LEN];
        hold = it.alarm_ringing | it.empty_box_alarm;
        case (it.kind)
            KIND_RX: begin
                if (rx_pos < FRAME_LEN - 1) begin
                    hdr_buf[rx_pos[1:0]] = it.rx_byte;
                    rx_pos++;
                end else begin
                    rx_pos = '0;
                    if (hdr_buf[0] == SYNC0_BYTE && hdr_buf[1] == SYNC1_BYTE &&
                        it.rx_byte == TAIL_BYTE) begin
                        if (admit_command(hdr_buf[2], hdr_buf[3], hold))
                            push_result(OUT_CMD, hdr_buf[2], hdr_buf[3], 8'h00, 1'b1);
                    end
                end
            end
            KIND_TICK: begin
                tick_now++;
            end
            KIND_PLAY: begin
                // same sound still inside its replay window is swallowed
                if (!(play_live && play_type_q == it.play_type && play_id_q == it.play_id &&
                      (tick_now - play_at) < replay_span)) begin
                    play_live   = 1'b1;
                    play_type_q = it.play_type;
                    play_id_q   = it.play_id;
                    play_at     = tick_now;
                    echo_live   = 1'b1;
                    echo_type   = it.play_type;
                    echo_id     = it.play_id;
                    echo_at     = tick_now;
                    tx_seq = '{SYNC0_BYTE, SYNC1_BYTE, it.play_type, it.play_id, TAIL_BYTE};
                    for (int k = 0; k < FRAME_LEN; k++)
                        push_result(OUT_TX, 8'h00, 8'h00, tx_seq[k], k == FRAME_LEN - 1);
                end
            end
            KIND_STOP: begin
                play_live   = 1'b0;
                play_type_q = '0;
                play_id_q   = '0;
            end
            KIND_WAKE: begin
                awake_q = 1'b1;
                wake_at = tick_now;
            end
            default: ;
        endcase
        if (echo_live && (tick_now - echo_at) > echo_span)
            echo_live = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        vcff_out_t   want;
        logic [31:0] reg_now;
        if (!aresetn) begin
            clear_filter();
            results_due.delete();
        end else begin
            if (psel && penable && pready) begin
                case (vcff_reg_t'(paddr[ADDR_W-1:2]))
                    REG_WAKE_TIMEOUT:  reg_now = wake_limit;
                    REG_ECHO_WINDOW:   reg_now = echo_span;
                    REG_REPEAT_WINDOW: reg_now = repeat_span;
                    default:           reg_now = replay_span;
                endcase
                if (pwrite) begin
                    case (vcff_reg_t'(paddr[ADDR_W-1:2]))
                        REG_WAKE_TIMEOUT:  wake_limit  = pwdata;
                        REG_ECHO_WINDOW:   echo_span   = pwdata;
                        REG_REPEAT_WINDOW: repeat_span = pwdata;
                        default:           replay_span = pwdata;
                    endcase
                end else begin
                    check_field("prdata", reg_now, prdata);
                end
            end
            if (s_valid && s_ready)
                filter_item(s_data);
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with nothing outstanding: 0x%0h", m_data);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("out_kind", 32'(want.out_kind), 32'(m_data.out_kind));
                    check_field("command_type", 32'(want.command_type),
                                32'(m_data.command_type));
                    check_field("command_id", 32'(want.command_id), 32'(m_data.command_id));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(m_data.tx_byte));
                    check_field("last", 32'(want.last), 32'(m_data.last));
                    check_field("awake", 32'(want.awake), 32'(m_data.awake));
                    check_field("playing", 32'(want.playing), 32'(m_data.playing));
                    check_field("frame_count", want.frame_count, m_data.frame_count);
                end
            end
        end
    end

    // published away from the sampling edge
    always @(negedge aclk) pending = results_due.size();

endmodule

### tb/tb_voice_command_frame_filter.sv
`timescale 1ns / 1ps

module tb_voice_command_frame_filter;
    import vcff_pkg::*;

    // kind codes the block has no use for
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    vcff_in_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    vcff_out_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;

    int         send_idle_pct = 0;
    int         rx_idle_pct   = 0;
    logic       rx_hold       = 1'b0;
    int         rx_slot       = 0;
    int         items_sent    = 0;
    logic [7:0] last_play_type = 8'h00;
    logic [7:0] last_play_id   = 8'h00;

    voice_command_frame_filter DUT (.*);

    vcff_stream_checker checker_i (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk)
        m_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    function automatic vcff_in_t scrambled(int hold_pct);
        vcff_in_t it;
        it.kind            = KIND_TICK;
        it.rx_byte         = 8'($urandom);
        it.play_type       = 8'($urandom);
        it.play_id         = 8'($urandom);
        it.alarm_ringing   = ($urandom_range(0, 99) < hold_pct);
        it.empty_box_alarm = ($urandom_range(0, 99) < hold_pct);
        return it;
    endfunction

    function automatic logic [15:0] pick_cmd();
        case ($urandom_range(0, 9))
            0:       return {CMD_TYPE_SYS, CMD_ID_SLEEP};
            1:       return {CMD_TYPE_SYS, CMD_ID_WAKE};
            2, 3:    return {last_play_type, last_play_id};
            4, 5, 6: return {8'h10 | 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1))};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(vcff_in_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.kind == KIND_RX)
            rx_slot = (rx_slot + 1) % FRAME_LEN;
        if (it.kind <= KIND_WAKE)
            items_sent++;
    endtask

    task automatic send_rx(logic [7:0] b, int hold_pct);
        vcff_in_t it;
        it         = scrambled(hold_pct);
        it.kind    = KIND_RX;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_op(logic [2:0] k);
        vcff_in_t it;
        it      = scrambled(15);
        it.kind = k;
        send_item(it);
    endtask

    task automatic send_play(logic [7:0] ty, logic [7:0] id);
        vcff_in_t it;
        it           = scrambled(15);
        it.kind      = KIND_PLAY;
        it.play_type = ty;
        it.play_id   = id;
        last_play_type = ty;
        last_play_id   = id;
        send_item(it);
    endtask

    // first byte in [39:32]; pads with junk until the byte counter is aligned
    task automatic send_frame(logic [39:0] fb, int hold_pct);
        while (rx_slot != 0) send_rx(8'($urandom), hold_pct);
        for (int i = 4; i >= 0; i--) send_rx(fb[8*i +: 8], hold_pct);
    endtask

    task automatic reg_access(logic wr, vcff_reg_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_back();
        for (int i = 0; i < 4; i++) reg_access(1'b0, vcff_reg_t'(i), '0);
    endtask

    task automatic program_regs(logic [31:0] wt, logic [31:0] ew, logic [31:0] rw,
                                logic [31:0] pw);
        reg_access(1'b1, REG_WAKE_TIMEOUT, wt);
        reg_access(1'b1, REG_ECHO_WINDOW, ew);
        reg_access(1'b1, REG_REPEAT_WINDOW, rw);
        reg_access(1'b1, REG_REPLAY_WINDOW, pw);
        read_back();
    endtask

    // quiet the sender and let every outstanding result drain
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        rx_idle_pct  <= recv_pct;
    endtask

    task automatic run_random(int n);
        int          stop_at;
        int          pick;
        logic [15:0] cmd;
        logic [39:0] fb;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            cmd  = pick_cmd();
            fb   = {SYNC0_BYTE, SYNC1_BYTE, cmd, TAIL_BYTE};
            if (pick < 42) begin
                send_frame(fb, 15);
            end else if (pick < 50) begin
                // break the header or the tail
                case ($urandom_range(0, 2))
                    0:       fb[39:32] ^= 8'($urandom_range(1, 255));
                    1:       fb[31:24] ^= 8'($urandom_range(1, 255));
                    default: fb[7:0]   ^= 8'($urandom_range(1, 255));
                endcase
                send_frame(fb, 15);
            end else if (pick < 70) begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6))
                    send_op(KIND_TICK);
            end else if (pick < 82) begin
                send_play(cmd[15:8], cmd[7:0]);
            end else if (pick < 88) begin
                send_op(KIND_STOP);
            end else if (pick < 91) begin
                send_op(KIND_WAKE);
            end else begin
                send_rx(8'($urandom), 15);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_back();

        set_idle(30, 68);
        // wake word, then a play request and its suppressed repeat
        send_frame({SYNC0_BYTE, SYNC1_BYTE, CMD_TYPE_SYS, CMD_ID_WAKE, TAIL_BYTE}, 0);
        send_play(8'hFF, 8'h00);
        send_play(8'hFF, 8'h00);
        // own transmission heard back
        send_frame({SYNC0_BYTE, SYNC1_BYTE, 8'hFF, 8'h00, TAIL_BYTE}, 0);
        send_op(KIND_STOP);
        // sleep while an alarm rings keeps the block awake
        send_frame({SYNC0_BYTE, SYNC1_BYTE, CMD_TYPE_SYS, CMD_ID_SLEEP, TAIL_BYTE}, 100);
        send_op(KIND_SPARE_LO);
        send_op(KIND_SPARE_HI);
        // bad header is dropped
        send_frame({8'h00, 8'hFF, 8'h00, 8'hFF, TAIL_BYTE}, 0);
        settle();

        program_regs($urandom_range(1, 40), $urandom_range(1, 20), $urandom_range(1, 20),
                     $urandom_range(1, 20));
        run_random(60);
        settle();

        set_idle(68, 30);
        program_regs(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(60);
        settle();

        set_idle(0, 0);
        program_regs(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        run_random(60);
        settle();

        // zero windows: every play emits, so a stalled receiver backs up the input
        program_regs(32'd5, 32'd0, 32'd0, 32'd0);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (400) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (8) begin
                    send_play(8'h10, 8'h20);
                    send_frame({SYNC0_BYTE, SYNC1_BYTE, 8'h10, 8'h20, TAIL_BYTE}, 0);
                end
            end
        join
        settle();

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/vcff_pkg.sv
design/vcff_regs.sv
design/vcff_core.sv
design/vcff_out.sv
design/voice_command_frame_filter.sv
tb/vcff_stream_checker.sv
tb/tb_voice_command_frame_filter.sv
